### sv/lpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

  localparam int unsigned IDX_W      = 7;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned CEIL_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FC_W       = 32;
  localparam int unsigned NUM_WAVES  = 3;

  localparam int unsigned WAVE_A    = 0;
  localparam int unsigned WAVE_B    = 1;
  localparam int unsigned WAVE_FADE = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_RATE_A = 3'd0,
    REG_PHASE_RATE_B = 3'd1,
    REG_FADE_RATE    = 3'd2,
    REG_FADE_CEILING = 3'd3
  } lpg_reg_e;

  localparam logic [RATE_W-1:0] RST_PHASE_RATE_A = 16'd3;
  localparam logic [RATE_W-1:0] RST_PHASE_RATE_B = 16'd7;
  localparam logic [RATE_W-1:0] RST_FADE_RATE    = 16'd7;
  localparam logic [CEIL_W-1:0] RST_FADE_CEILING = 8'd220;

  localparam logic [7:0] PHASE_LO  = 8'd192;
  localparam logic [7:0] PHASE_HI  = 8'd64;
  localparam logic [7:0] COS_OFS   = 8'd64;
  localparam logic [7:0] SECTOR_1  = 8'd85;
  localparam logic [7:0] SECTOR_2  = 8'd170;
  localparam logic [7:0] DIM_FLOOR = 8'd2;
  localparam logic [7:0] SINE_MID  = 8'd128;

  localparam logic [7:0] SINE_SEG [8] = '{
    8'd0, 8'd49, 8'd49, 8'd41, 8'd90, 8'd27, 8'd117, 8'd10
  };

  typedef struct packed {
    logic [RATE_W-1:0] phase_rate_a;
    logic [RATE_W-1:0] phase_rate_b;
    logic [RATE_W-1:0] fade_rate;
    logic [CEIL_W-1:0] fade_ceiling;
  } lpg_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINE,
    ST_SCALE,
    ST_SQUARE,
    ST_CUBE,
    ST_COLOR
  } lpg_state_e;

  typedef struct packed {
    logic load;
    logic sine;
    logic scale;
    logic square;
    logic cube;
    logic color;
  } lpg_cmd_t;

  typedef struct packed {
    logic out_free;
  } lpg_sts_t;

  function automatic logic [7:0] wave_sin(input logic [7:0] theta);
    logic [5:0]  off;
    logic [4:0]  frac;
    logic [1:0]  sect;
    logic [7:0]  base;
    logic [7:0]  slope;
    logic [12:0] prod;
    logic [7:0]  y;
    off   = theta[6] ? ~theta[5:0] : theta[5:0];
    frac  = {1'b0, off[3:0]} + {4'b0, theta[6]};
    sect  = off[5:4];
    base  = SINE_SEG[{sect, 1'b0}];
    slope = SINE_SEG[{sect, 1'b1}];
    prod  = 13'(slope) * 13'(frac);
    y     = prod[11:4] + base;
    if (theta[7]) begin
      y = 8'd0 - y;
    end
    return y + SINE_MID;
  endfunction

  function automatic logic [7:0] mul_scale(input logic [7:0] v, input logic [7:0] s);
    logic [16:0] p;
    p = 17'(v) * (17'(s) + 17'd1);
    return p[15:8];
  endfunction

endpackage

`default_nettype wire

### sv/lpg_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lpg_in_if;
  logic                      valid;
  logic                      ready;
  logic [lpg_pkg::IDX_W-1:0] led_index;
  logic                      frame_last;

  modport source (output valid, output led_index, output frame_last, input ready);
  modport sink   (input valid, input led_index, input frame_last, output ready);
endinterface

`default_nettype wire

### sv/lpg_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lpg_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpg_pkg::COLOR_W-1:0] red;
  logic [lpg_pkg::COLOR_W-1:0] green;
  logic [lpg_pkg::COLOR_W-1:0] blue;
  logic                        frame_done;

  modport source (output valid, output red, output green, output blue, output frame_done,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input frame_done,
                  output ready);
endinterface

`default_nettype wire

### sv/lpg_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module lpg_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lpg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lpg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output lpg_pkg::lpg_cfg_t                 cfg_o
);
  import lpg_pkg::*;

  lpg_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PHASE_RATE_A: cfg_d.phase_rate_a = cfg_data_i[RATE_W-1:0];
        REG_PHASE_RATE_B: cfg_d.phase_rate_b = cfg_data_i[RATE_W-1:0];
        REG_FADE_RATE:    cfg_d.fade_rate    = cfg_data_i[RATE_W-1:0];
        REG_FADE_CEILING: cfg_d.fade_ceiling = cfg_data_i[CEIL_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_rate_a <= RST_PHASE_RATE_A;
      cfg_q.phase_rate_b <= RST_PHASE_RATE_B;
      cfg_q.fade_rate    <= RST_FADE_RATE;
      cfg_q.fade_ceiling <= RST_FADE_CEILING;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### sv/lpg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lpg_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lpg_pkg::lpg_cfg_t           cfg_i,
  input  wire lpg_pkg::lpg_cmd_t           cmd_i,
  output lpg_pkg::lpg_sts_t                sts_o,
  input  wire logic [lpg_pkg::IDX_W-1:0]   led_index_i,
  input  wire logic                        frame_last_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [lpg_pkg::COLOR_W-1:0]      red_o,
  output logic [lpg_pkg::COLOR_W-1:0]      green_o,
  output logic [lpg_pkg::COLOR_W-1:0]      blue_o,
  output logic                             frame_done_o
);
  import lpg_pkg::*;

  logic [FC_W-1:0]   fc_q, fc_d;
  logic [IDX_W-1:0]  idx_q;
  logic              last_q;
  logic [FC_W-1:0]   prod_q [NUM_WAVES];
  logic [7:0]        sine_q [NUM_WAVES];
  logic [7:0]        ph_a_q, ph_b_q, fade_q;
  logic [7:0]        tri_q, sq_q, cos_q, ci_q;
  logic [7:0]        red_q, green_q, blue_q;
  logic              done_q;
  logic              out_valid_q, out_valid_d;

  logic [RATE_W-1:0] rate     [NUM_WAVES];
  logic [RATE_W-1:0] bpm      [NUM_WAVES];
  logic [FC_W-1:0]   prod_d   [NUM_WAVES];
  logic [FC_W-1:0]   beat_acc [NUM_WAVES];
  logic [7:0]        sine_d   [NUM_WAVES];

  logic [7:0]  x, xf, tri_d, cu;
  logic [15:0] sq3, cu2, ease_raw;
  logic [7:0]  ease, ci_d, bright, p, p3, r_w, g_w, b_w;

  assign rate[WAVE_A]    = cfg_i.phase_rate_a;
  assign rate[WAVE_B]    = cfg_i.phase_rate_b;
  assign rate[WAVE_FADE] = cfg_i.fade_rate;

  always_comb begin
    for (int i = 0; i < NUM_WAVES; i++) begin
      bpm[i]      = (rate[i][RATE_W-1:8] == '0) ? {rate[i][7:0], 8'h00} : rate[i];
      prod_d[i]   = fc_q * {16'b0, bpm[i]};
      // times 280 = 256 + 16 + 8
      beat_acc[i] = (prod_q[i] << 8) + (prod_q[i] << 4) + (prod_q[i] << 3);
      sine_d[i]   = wave_sin(beat_acc[i][FC_W-1:FC_W-8]);
    end
  end

  always_comb begin
    x        = {idx_q, 1'b0} + ph_a_q;
    xf       = x[7] ? ~x : x;
    tri_d    = {xf[6:0], 1'b0};
    cu       = mul_scale(sq_q, tri_q);
    sq3      = {8'b0, sq_q} + {7'b0, sq_q, 1'b0};
    cu2      = {7'b0, cu, 1'b0};
    ease_raw = sq3 - cu2;
    ease     = ease_raw[8] ? 8'hFF : ease_raw[7:0];
    ci_d     = {1'b0, ease[7:1]} + {1'b0, cos_q[7:1]};
  end

  always_comb begin
    bright = (ci_q > fade_q) ? (ci_q - fade_q) : 8'd0;
    p      = ~ci_q;
    r_w    = '0;
    g_w    = '0;
    b_w    = '0;
    if (p < SECTOR_1) begin
      p3  = {p[6:0], 1'b0} + p;
      r_w = 8'hFF - p3;
      b_w = p3;
    end else if (p < SECTOR_2) begin
      p3  = {p[6:0], 1'b0} + p - {SECTOR_1[6:0], 1'b0} - SECTOR_1;
      g_w = p3;
      b_w = 8'hFF - p3;
    end else begin
      p3  = {p[6:0], 1'b0} + p - {SECTOR_2[6:0], 1'b0} - SECTOR_2;
      r_w = p3;
      g_w = 8'hFF - p3;
    end
  end

  always_comb begin
    fc_d        = fc_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.color) begin
      out_valid_d = 1'b1;
      if (last_q) begin
        fc_d = fc_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fc_q        <= fc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q  <= led_index_i;
      last_q <= frame_last_i;
      for (int i = 0; i < NUM_WAVES; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
    if (cmd_i.sine) begin
      for (int i = 0; i < NUM_WAVES; i++) begin
        sine_q[i] <= sine_d[i];
      end
    end
    if (cmd_i.scale) begin
      ph_a_q <= PHASE_LO + mul_scale(sine_q[WAVE_A], PHASE_HI - PHASE_LO);
      ph_b_q <= PHASE_LO + mul_scale(sine_q[WAVE_B], PHASE_HI - PHASE_LO);
      fade_q <= mul_scale(sine_q[WAVE_FADE], cfg_i.fade_ceiling);
    end
    if (cmd_i.square) begin
      tri_q <= tri_d;
      sq_q  <= mul_scale(tri_d, tri_d);
      cos_q <= wave_sin({1'b0, idx_q} + ph_b_q + COS_OFS);
    end
    if (cmd_i.cube) begin
      ci_q <= ci_d;
    end
    if (cmd_i.color) begin
      red_q   <= r_w;
      green_q <= (g_w > bright) ? (g_w - bright) : DIM_FLOOR;
      blue_q  <= (b_w > bright) ? (b_w - bright) : DIM_FLOOR;
      done_q  <= last_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign frame_done_o   = done_q;

  a_fc_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fc_q != $past(fc_q)) |-> ($past(cmd_i.color) && $past(last_q)))
    else $error("frame counter moved without a last-of-frame result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_i.color)
    else $error("held result overwritten");

  a_valid_from_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.color))
    else $error("result valid without a color step");

endmodule

`default_nettype wire

### sv/lpg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lpg_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire lpg_pkg::lpg_sts_t sts_i,
  output lpg_pkg::lpg_cmd_t      cmd_o
);
  import lpg_pkg::*;

  lpg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SINE;
        end
      end
      ST_SINE: begin
        cmd_o.sine = 1'b1;
        state_d    = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_CUBE;
      end
      ST_CUBE: begin
        cmd_o.cube = 1'b1;
        state_d    = ST_COLOR;
      end
      ST_COLOR: begin
        if (sts_i.out_free) begin
          cmd_o.color = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath step at once");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SINE))
    else $error("transfer did not start the sequence");

  a_color_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.color |-> sts_i.out_free)
    else $error("color step issued while output is held");

endmodule

`default_nettype wire

### sv/led_plasma_pattern_generator_top.sv
// Plasma LED pattern generator.
// Input channel (in_i): one LED index per transfer, with frame_last marking
// the last LED of a frame. Output channel (out_o): one RGB color per input
// transfer, in order, with frame_done copying frame_last.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 phase_rate_a, 1 phase_rate_b, 2 fade_rate, 3 fade_ceiling); other
// indexes are ignored. Write only while no item is in flight.
// Sequencing: each item runs the beat product, sine, scaling, square, cube
// and color wheel steps one after another under the sequencer; a new item
// is taken only once the color step of the previous one has been issued.
// The 32-bit frame counter advances when the last-of-frame result is loaded.
// Reset: frame counter cleared, registers back to 3, 7, 7 and 220, output
// empty. A stalled receiver holds the result in the output register; the
// next item is still taken and waits before its color step until the
// register drains.
`timescale 1ns / 1ps
`default_nettype none

module led_plasma_pattern_generator_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lpg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lpg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lpg_in_if.sink                              in_i,
  lpg_out_if.source                           out_o
);
  import lpg_pkg::*;

  lpg_cfg_t cfg;
  lpg_cmd_t cmd;
  lpg_sts_t sts;
  logic     in_ready;

  lpg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lpg_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .led_index_i  (in_i.led_index),
    .frame_last_i (in_i.frame_last),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .red_o        (out_o.red),
    .green_o      (out_o.green),
    .blue_o       (out_o.blue),
    .frame_done_o (out_o.frame_done)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lpg_pkg::*;

  localparam int unsigned STUCK_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  localparam logic [7:0] SINE_KNOTS [8] = '{
    8'd0, 8'd49, 8'd49, 8'd41, 8'd90, 8'd27, 8'd117, 8'd10
  };

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               frame_done;
  } led_color_t;

  typedef enum logic {
    ROW_LED,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] value;
    logic [IDX_W-1:0]      led;
    logic                  last;
    logic                  known;
    led_color_t            color;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lpg_in_if  in_if ();
  lpg_out_if out_if ();

  led_plasma_pattern_generator_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  logic [FC_W-1:0]   frame_count;
  logic [RATE_W-1:0] rate_a;
  logic [RATE_W-1:0] rate_b;
  logic [RATE_W-1:0] fade_rt;
  logic [CEIL_W-1:0] fade_ceil;

  led_color_t  colors_expected[$];
  int unsigned mismatches;
  int unsigned stuck_cycles = 0;
  logic        hold_req;
  logic        no_idle;

  always #5 clk = ~clk;

  function automatic logic [7:0] sine8(input logic [7:0] theta);
    logic [7:0] off;
    logic [7:0] frac;
    logic [1:0] sect;
    logic [7:0] base;
    logic [7:0] slope;
    logic [7:0] y;
    logic [31:0] prod;
    off = theta[6] ? 8'(8'd255 - theta) : theta;
    off = off & 8'h3F;
    frac = off & 8'h0F;
    if (theta[6]) begin
      frac = frac + 8'd1;
    end
    sect  = off[5:4];
    base  = SINE_KNOTS[{sect, 1'b0}];
    slope = SINE_KNOTS[{sect, 1'b1}];
    prod  = 32'(slope) * 32'(frac);
    y     = prod[11:4] + base;
    if (theta[7]) begin
      y = 8'd0 - y;
    end
    return y + 8'd128;
  endfunction

  function automatic logic [7:0] scale8(input logic [7:0] v, input logic [7:0] s);
    logic [31:0] p;
    p = 32'(v) * (32'(s) + 32'd1);
    return p[15:8];
  endfunction

  function automatic logic [7:0] beat_wave(input logic [RATE_W-1:0] rate,
                                           input logic [7:0] lo, input logic [7:0] hi);
    logic [31:0] bpm;
    logic [31:0] prod;
    logic [7:0]  width;
    bpm = 32'(rate);
    if (bpm < 32'd256) begin
      bpm = bpm << 8;
    end
    prod  = frame_count * bpm * 32'd280;
    width = hi - lo;
    return lo + scale8(sine8(prod[31:24]), width);
  endfunction

  function automatic logic [7:0] ease3(input logic [7:0] i);
    logic [7:0]  sq;
    logic [7:0]  cu;
    logic [31:0] r;
    sq = scale8(i, i);
    cu = scale8(sq, i);
    r  = (32'd3 * 32'(sq) - 32'd2 * 32'(cu)) & 32'h0000FFFF;
    if (r[8]) begin
      return 8'd255;
    end
    return r[7:0];
  endfunction

  function automatic logic [7:0] tri_ease(input logic [7:0] x);
    logic [7:0] t;
    t = x[7] ? 8'(8'd255 - x) : x;
    return ease3({t[6:0], 1'b0});
  endfunction

  function automatic led_color_t predict_color(input logic [IDX_W-1:0] led,
                                               input logic last);
    logic [7:0] ph_a;
    logic [7:0] ph_b;
    logic [7:0] fade;
    logic [7:0] tri_arg;
    logic [7:0] cos_arg;
    logic [7:0] ci;
    logic [7:0] bright;
    logic [7:0] p;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    led_color_t c;
    ph_a    = beat_wave(rate_a, 8'd192, 8'd64);
    ph_b    = beat_wave(rate_b, 8'd192, 8'd64);
    fade    = beat_wave(fade_rt, 8'd0, fade_ceil);
    tri_arg = {led, 1'b0} + ph_a;
    cos_arg = {1'b0, led} + ph_b + 8'd64;
    ci      = (tri_ease(tri_arg) >> 1) + (sine8(cos_arg) >> 1);
    bright  = (ci > fade) ? 8'(ci - fade) : 8'd0;
    p = 8'd255 - ci;
    if (p < 8'd85) begin
      r = 8'd255 - p * 8'd3;
      g = 8'd0;
      b = p * 8'd3;
    end else if (p < 8'd170) begin
      p = p - 8'd85;
      r = 8'd0;
      g = p * 8'd3;
      b = 8'd255 - p * 8'd3;
    end else begin
      p = p - 8'd170;
      r = p * 8'd3;
      g = 8'd255 - p * 8'd3;
      b = 8'd0;
    end
    c.red        = r;
    c.green      = (g > bright) ? 8'(g - bright) : 8'd2;
    c.blue       = (b > bright) ? 8'(b - bright) : 8'd2;
    c.frame_done = last;
    return c;
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 3))
      0: return RATE_W'($urandom_range(1, 255));
      1: return RATE_W'($urandom_range(256, 65535));
      2: return RATE_W'($urandom_range(65000, 65535));
      default: return RATE_W'($urandom);
    endcase
  endfunction

  function automatic stim_row_t led_row(input logic [IDX_W-1:0] led, input logic last);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_LED;
    row.led  = led;
    row.last = last;
    return row;
  endfunction

  function automatic stim_row_t led_row_known(input logic [IDX_W-1:0] led, input logic last,
                                              input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    stim_row_t row;
    row       = led_row(led, last);
    row.known = 1'b1;
    row.color = '{red: r, green: g, blue: b, frame_done: last};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.value   = value;
    return row;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PHASE_RATE_A: rate_a    = value[RATE_W-1:0];
      REG_PHASE_RATE_B: rate_b    = value[RATE_W-1:0];
      REG_FADE_RATE:    fade_rt   = value[RATE_W-1:0];
      REG_FADE_CEILING: fade_ceil = value[CEIL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_idle();
    in_if.valid <= 1'b0;
    while (colors_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_led(input logic [IDX_W-1:0] led, input logic last,
                          input logic known, input led_color_t color);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.led_index  <= led;
    in_if.frame_last <= last;
    do @(posedge clk); while (!in_if.ready);
    colors_expected.push_back(known ? color : predict_color(led, last));
    if (last) begin
      frame_count = frame_count + 1;
    end
  endtask

  initial begin
    stim_row_t   rows[$];
    int unsigned items;
    int unsigned len;
    logic [IDX_W-1:0] start;
    in_if.valid      <= 1'b0;
    in_if.led_index  <= '0;
    in_if.frame_last <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    rst_ni           <= 1'b0;
    hold_req    = 1'b0;
    no_idle     = 1'b0;
    frame_count = '0;
    rate_a      = RST_PHASE_RATE_A;
    rate_b      = RST_PHASE_RATE_B;
    fade_rt     = RST_FADE_RATE;
    fade_ceil   = RST_FADE_CEILING;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    rows.push_back(led_row_known(7'd0, 1'b0, 8'd0, 8'd112, 8'd109));
    rows.push_back(led_row_known(7'd0, 1'b1, 8'd0, 8'd112, 8'd109));
    rows.push_back(led_row(7'd127, 1'b0));
    rows.push_back(led_row(7'd85, 1'b1));
    rows.push_back(cfg_row(REG_SPARE_FIRST, 16'hFFFF));
    rows.push_back(cfg_row(REG_PHASE_RATE_A, 16'd1));
    rows.push_back(cfg_row(REG_PHASE_RATE_B, 16'hFFFF));
    rows.push_back(cfg_row(REG_FADE_RATE, 16'd255));
    rows.push_back(cfg_row(REG_FADE_CEILING, 16'd0));
    rows.push_back(led_row(7'd127, 1'b1));
    rows.push_back(led_row(7'd42, 1'b1));
    rows.push_back(led_row(7'd0, 1'b1));
    rows.push_back(cfg_row(REG_PHASE_RATE_A, 16'hFFFF));
    rows.push_back(cfg_row(REG_PHASE_RATE_B, 16'd0));
    rows.push_back(cfg_row(REG_FADE_RATE, 16'hFFFF));
    rows.push_back(cfg_row(REG_FADE_CEILING, 16'hFFFF));
    rows.push_back(led_row(7'd127, 1'b1));
    rows.push_back(led_row(7'd1, 1'b1));
    rows.push_back(led_row(7'd126, 1'b1));
    rows.push_back(cfg_row(REG_PHASE_RATE_A, 16'd256));
    rows.push_back(cfg_row(REG_PHASE_RATE_B, 16'd255));
    rows.push_back(cfg_row(REG_FADE_RATE, 16'd0));
    rows.push_back(cfg_row(REG_FADE_CEILING, 16'd1));
    rows.push_back(cfg_row(REG_SPARE_LAST, 16'h0000));
    rows.push_back(led_row(7'd100, 1'b1));
    rows.push_back(led_row(7'd27, 1'b0));
    rows.push_back(led_row(7'd27, 1'b1));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain_idle();
        write_reg(rows[i].reg_idx, rows[i].value);
      end else begin
        send_led(rows[i].led, rows[i].last, rows[i].known, rows[i].color);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_idle();
      write_reg(REG_PHASE_RATE_A, pick_rate());
      write_reg(REG_PHASE_RATE_B, pick_rate());
      write_reg(REG_FADE_RATE, pick_rate());
      write_reg(REG_FADE_CEILING, CFG_DATA_W'($urandom));
      if (ph % 2 == 1) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  CFG_DATA_W'($urandom));
      end
      no_idle = (ph == 3);
      items = 0;
      while (items < PHASE_ITEMS) begin
        if (ph == 2 && items >= 100 && items < 110) begin
          hold_req = 1'b1;
        end
        if (ph == 5 && items >= 120 && items < 128) begin
          drain_idle();
          items = 128;
        end
        if ($urandom_range(0, 9) == 0) begin
          send_led(IDX_W'($urandom), 1'($urandom), 1'b0, '0);
          items++;
        end else begin
          len   = $urandom_range(1, 8);
          start = IDX_W'($urandom);
          for (int j = 0; j < len; j++) begin
            send_led(IDX_W'(start + j), (j == len - 1), 1'b0, '0);
          end
          items += len;
        end
      end
    end

    drain_idle();
    if (mismatches == 0 && colors_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    led_color_t  got;
    led_color_t  want;
    logic        held;
    held       = 1'b0;
    mismatches = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req && !held) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held = 1'b1;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got = '{red: out_if.red, green: out_if.green, blue: out_if.blue,
              frame_done: out_if.frame_done};
      if (colors_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected color transfer: r=%0d g=%0d b=%0d done=%0d",
                   got.red, got.green, got.blue, got.frame_done);
        end
      end else begin
        want = colors_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("color mismatch: exp r=%0d g=%0d b=%0d d=%0d, got r=%0d g=%0d b=%0d d=%0d",
                     want.red, want.green, want.blue, want.frame_done,
                     got.red, got.green, got.blue, got.frame_done);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
